FILE: rtl/lde_pkg.sv
// package for the list deque engine: payload structs, codes, sizes and
// the command and status groups between controller and datapath
// no dependencies
`default_nettype none

package lde_pkg;

  // store geometry
  localparam int unsigned Depth      = 256;
  localparam int unsigned DataW      = 32;
  localparam int unsigned IdxW       = $clog2(Depth);
  localparam int unsigned CntW       = $clog2(Depth + 1);

  // request and result field widths
  localparam int unsigned ValueW     = 32;
  localparam int unsigned PosW       = 31;
  localparam int unsigned CountW     = 9;
  localparam int unsigned StepW      = $clog2(PosW);

  typedef enum logic [1:0] {
    ReqPushFront = 2'd0,
    ReqPushBack  = 2'd1,
    ReqPopFront  = 2'd2,
    ReqRead      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    req_e                     req_type;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] data;
    status_e                  status;
    logic [CountW-1:0]        count;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic access;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  // value field to stored width, sign-extended or truncated
  function automatic logic [DataW-1:0] to_store(logic signed [ValueW-1:0] v);
    return DataW'(v);
  endfunction

  // stored entry back to the data field, sign-extended
  function automatic logic signed [ValueW-1:0] from_store(logic [DataW-1:0] s);
    return ValueW'(signed'(s));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lde_divmod.sv
// restoring remainder unit: position modulo element count, one bit a cycle
// depends on lde_pkg
`default_nettype none

module lde_divmod import lde_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [CntW-1:0] rem_o
);

  logic            busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PosW-1:0] dvd_q, dvd_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW:0]   trial;
  logic            last_step;

  assign last_step = (step_q == StepW'(PosW - 1));
  assign trial     = {rem_q, dvd_q[PosW-1]};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[PosW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CntW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = CntW'(trial);
      end
      step_d = step_q + StepW'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && last_step;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/lde_datapath.sv
// datapath: request register, ring store, head and count, remainder unit
// and the result register; depends on lde_pkg and lde_divmod
`default_nettype none

module lde_datapath import lde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  logic     out_stall_i,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  output logic     out_valid_o,
  output out_rsp_t out_rsp_o
);

  logic [DataW-1:0] mem_q [Depth];

  req_e              req_type_q;
  logic signed [ValueW-1:0] value_q;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DataW-1:0]  rd_data_q;
  logic              rd_ok_q, rd_ok_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_q, out_d;

  logic              we, re;
  logic [IdxW-1:0]   addr;
  logic              full, empty;
  logic              div_done;
  logic [CntW-1:0]   rem;
  logic [CntW-1:0]   pos_m1;
  logic [IdxW-1:0]   head_dec, head_inc;

  // sum of two in-range indices, brought back into the ring
  function automatic logic [IdxW-1:0] wrap(logic [IdxW:0] s);
    logic [IdxW:0] r;
    r = (s >= (IdxW+1)'(Depth)) ? s - (IdxW+1)'(Depth) : s;
    return r[IdxW-1:0];
  endfunction

  lde_divmod u_divmod (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (in_req_i.position),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? IdxW'(Depth - 1) : head_q - IdxW'(1);
  assign head_inc = wrap((IdxW+1)'(head_q) + (IdxW+1)'(1));
  // a remainder of zero picks the last element
  assign pos_m1   = (rem == '0) ? count_q - CntW'(1) : rem - CntW'(1);

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    addr     = head_q;
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    rd_ok_d  = rd_ok_q;
    if (cmd_i.access) begin
      status_d = StOk;
      rd_ok_d  = 1'b0;
      unique case (req_type_q)
        ReqPushFront: begin
          if (full) begin
            status_d = StFull;
          end else begin
            we      = 1'b1;
            addr    = head_dec;
            head_d  = head_dec;
            count_d = count_q + CntW'(1);
          end
        end
        ReqPushBack: begin
          if (full) begin
            status_d = StFull;
          end else begin
            we      = 1'b1;
            addr    = wrap((IdxW+1)'(head_q) + (IdxW+1)'(count_q));
            count_d = count_q + CntW'(1);
          end
        end
        ReqPopFront: begin
          if (empty) begin
            status_d = StEmpty;
          end else begin
            re      = 1'b1;
            rd_ok_d = 1'b1;
            addr    = head_q;
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
        ReqRead: begin
          if (empty) begin
            status_d = StEmpty;
          end else begin
            re      = 1'b1;
            rd_ok_d = 1'b1;
            addr    = wrap((IdxW+1)'(head_q) + (IdxW+1)'(pos_m1));
          end
        end
        default: ;
      endcase
    end
  end

  // result register: loaded on emit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_d.data   = rd_ok_q ? from_store(rd_data_q) : '0;
      out_d.status = status_q;
      out_d.count  = CountW'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= to_store(value_q);
    end
    if (re) begin
      rd_data_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= in_req_i.req_type;
      value_q    <= in_req_i.value;
    end
    status_q <= status_d;
    rd_ok_q  <= rd_ok_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.need_div = (in_req_i.req_type == ReqRead) && !empty;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

FILE: rtl/lde_ctrl.sv
// controller state machine: accept, remainder, store access, result
// depends on lde_pkg
`default_nettype none

module lde_ctrl import lde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDiv    = 4'b0010,
    StAccess = 4'b0100,
    StResult = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.need_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = StDiv;
          end else begin
            state_d = StAccess;
          end
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StAccess;
        end
      end
      StAccess: begin
        cmd_o.access = 1'b1;
        state_d      = StResult;
      end
      StResult: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

FILE: rtl/list_deque_engine.sv
// list deque engine: a bounded deque of signed values in a 256-entry ring
// one request at a time: a new request is accepted only once the previous
// result has been loaded into the result register; a read first runs the
// 31-step remainder unit (position modulo count, one bit per cycle)
// reset: asynchronous active low, clears head, count and handshake state;
// the store itself is not cleared and needs no clearing pass
`default_nettype none

module list_deque_engine import lde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  // request channel
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  // result channel
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, remainder, store access, result hand-off
  lde_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // store, pointers, remainder unit and the result register; the result
  // register lets a new request in while the previous result still waits
  lde_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .in_req_i,
    .out_stall_i,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o,
    .out_rsp_o
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for list_deque_engine: directed and random deque requests
// with random idling on both channels, each result checked against a local deque model
// depends on lde_pkg and the list_deque_engine rtl
module tb_top;
  import lde_pkg::*;

  // idle cycles with no handshake on either channel before the run is abandoned
  localparam int unsigned WatchdogLimit = 2000;
  // settle time after the last result, a little over the read latency
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomReqs = 1500;

  logic     clk;
  logic     rst_ni;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  list_deque_engine dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // requests waiting to be driven, and results the deque model has worked out
  in_req_t     queued_reqs[$];
  out_rsp_t    predicted_rsps[$];
  int unsigned total_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned error_count = 0;

  // local copy of the deque state
  logic [DataW-1:0] model_store[Depth];
  int unsigned      model_head = 0;
  int unsigned      model_count = 0;

  // idling control
  logic        req_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned calm_left = 100;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  // clock and the single reset at the start of the run
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(negedge clk);
    rst_ni = 1'b1;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic in_req_t make_request(input req_e kind, input logic [31:0] val,
                                           input logic [PosW-1:0] pos);
    in_req_t r;
    r.req_type = kind;
    r.value    = val;
    r.position = pos;
    return r;
  endfunction

  // deque model: applies one request to the local state and returns its result
  function automatic out_rsp_t deque_predict(input in_req_t r);
    out_rsp_t    rsp;
    int unsigned p;
    int unsigned slot;
    rsp.data   = '0;
    rsp.status = StOk;
    case (r.req_type)
      ReqPushFront, ReqPushBack: begin
        if (model_count >= Depth) begin
          // full: nothing moves
          rsp.status = StFull;
        end else if (r.req_type == ReqPushFront) begin
          model_head = (model_head + Depth - 1) % Depth;
          model_store[model_head] = DataW'(r.value);
          model_count++;
        end else begin
          model_store[(model_head + model_count) % Depth] = DataW'(r.value);
          model_count++;
        end
      end
      default: begin
        if (model_count == 0) begin
          rsp.status = StEmpty;
        end else if (r.req_type == ReqPopFront) begin
          rsp.data   = ValueW'(signed'(model_store[model_head]));
          model_head = (model_head + 1) % Depth;
          model_count--;
        end else begin
          // a remainder of zero picks the last element
          p = r.position % model_count;
          if (p == 0) p = model_count;
          slot     = (model_head + p - 1) % Depth;
          rsp.data = ValueW'(signed'(model_store[slot]));
        end
      end
    endcase
    rsp.count = CountW'(model_count);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // request driver: holds a stalled request, otherwise idles or presents the next one
  always @(negedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && !req_taken) begin
        // payload stays as it is while stalled
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left = gap_left - 1;
      end else if (queued_reqs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= queued_reqs.pop_front();
        gap_left = calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall, plus stretches where neither side idles
  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(50, 400);
    end else begin
      calm_left = calm_left - 1;
    end
    if (stall_left > 0 && !calm) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
    end
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    out_rsp_t want;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted_rsps.push_back(deque_predict(in_req_i));
      accepted_reqs++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_rsps.size() == 0) begin
        report_mismatch("result with no request outstanding", out_rsp_o.data, '0);
      end else begin
        want = predicted_rsps.pop_front();
        if (out_rsp_o.data !== want.data)
          report_mismatch("data", out_rsp_o.data, want.data);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (out_rsp_o.count !== want.count)
          report_mismatch("count", 32'(out_rsp_o.count), 32'(want.count));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus, then wait for the last result and settle
  initial begin
    int unsigned gen_count;
    int unsigned over_tries;
    int unsigned over_limit;
    int unsigned r;
    logic        growing;
    req_e        kind;
    logic [31:0] val;
    logic [PosW-1:0] pos;

    // empty store: read and pop both report empty
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd1));
    queued_reqs.push_back(make_request(ReqPopFront, $urandom, PosW'($urandom)));
    // value extremes at both ends
    queued_reqs.push_back(make_request(ReqPushFront, 32'h7fff_ffff, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqPushBack, 32'h8000_0000, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqPushFront, 32'hffff_ffff, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqPushBack, 32'h0000_0000, PosW'($urandom)));
    // reads: head, exact count, zero, largest position, plain
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd1));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd4));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd0));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'h7fff_ffff));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd2));
    queued_reqs.push_back(make_request(ReqPushBack, 32'h5555_5555, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqPushFront, 32'haaaa_aaaa, PosW'($urandom)));
    // six held: a multiple of the count and a wrap past it
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd12));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'd7));
    // drain to empty and poke the empty store again
    repeat (6) queued_reqs.push_back(make_request(ReqPopFront, $urandom, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqPopFront, $urandom, PosW'($urandom)));
    queued_reqs.push_back(make_request(ReqRead, $urandom, 31'h7fff_ffff));

    // random part: alternate fill and drain sweeps so that full and empty both recur
    gen_count  = 0;
    growing    = 1'b1;
    over_tries = 0;
    over_limit = $urandom_range(2, 6);
    repeat (RandomReqs) begin
      r = $urandom_range(0, 99);
      if (growing)
        kind = (r < 75) ? ((r < 38) ? ReqPushFront : ReqPushBack) :
               (r < 85) ? ReqPopFront : ReqRead;
      else
        kind = (r < 70) ? ReqPopFront :
               (r < 85) ? ((r < 78) ? ReqPushFront : ReqPushBack) : ReqRead;

      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7fff_ffff;
          2:       val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end else begin
        val = $urandom;
      end

      r = $urandom_range(0, 9);
      if (r == 0)
        pos = '0;
      else if (r == 1)
        pos = '1;
      else if (r < 4)
        pos = PosW'((gen_count == 0 ? 1 : gen_count) * $urandom_range(1, 4));
      else if (r < 7)
        pos = PosW'($urandom_range(1, 2 * gen_count + 1));
      else
        pos = PosW'($urandom);

      queued_reqs.push_back(make_request(kind, val, pos));

      // track the fill level to steer the sweeps
      if (kind == ReqPushFront || kind == ReqPushBack) begin
        if (gen_count < Depth) gen_count++;
      end else if (kind == ReqPopFront) begin
        if (gen_count > 0) gen_count--;
      end
      if (growing && gen_count == Depth) begin
        over_tries++;
        if (over_tries > over_limit) begin
          growing    = 1'b0;
          over_tries = 0;
          over_limit = $urandom_range(2, 6);
        end
      end else if (!growing && gen_count == 0) begin
        over_tries++;
        if (over_tries > over_limit) begin
          growing    = 1'b1;
          over_tries = 0;
          over_limit = $urandom_range(2, 6);
        end
      end
    end
    total_reqs = queued_reqs.size();

    // counters only move at the rising edge, so look at them on the falling one
    do @(negedge clk);
    while (accepted_reqs != total_reqs || predicted_rsps.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lde_pkg.sv
rtl/lde_divmod.sv
rtl/lde_datapath.sv
rtl/lde_ctrl.sv
rtl/list_deque_engine.sv
verif/tb_top.sv
